@@ src/bclp_pkg.sv @@
// Shared constants for the button click / long-press detector.
// Depends on nothing; imported by button_click_long_press_detector_top and its testbench.
package bclp_pkg;

  // Raw samples per debounce window.
  localparam int WINDOW_SAMPLES = 10;
  localparam int IDX_W          = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int VOTE_W         = $clog2(WINDOW_SAMPLES + 1);

  // Register widths and the configuration port.
  localparam int THR_W    = 4;
  localparam int CNT_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int CMP_W    = (VOTE_W > THR_W) ? VOTE_W : THR_W;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_VOTE_THRESHOLD   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LONG_PRESS_COUNT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RELEASE_COUNT    = 2'd2;
  localparam logic [CFG_AW-1:0] REG_EVENT_HOLD_LIMIT = 2'd3;

  // Register reset values.
  localparam logic [THR_W-1:0] VOTE_THRESHOLD_RST   = 4'd8;
  localparam logic [CNT_W-1:0] LONG_PRESS_COUNT_RST = 16'd100;
  localparam logic [CNT_W-1:0] RELEASE_COUNT_RST    = 16'd5;
  localparam logic [CNT_W-1:0] EVENT_HOLD_LIMIT_RST = 16'd200;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Event codes.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // Payload widths on the stream channels.
  localparam int IN_DW  = 8;
  localparam int OUT_DW = 8;

endpackage

@@ src/button_click_long_press_detector_top.sv @@
// Button click / long-press detector: debounce voting and event classifier.
// Depends on bclp_pkg.
//
// Usage: every request on the s_axis channel is one sample tick. s_axis_tdata
// carries the raw button level and a read flag that fetches and clears the
// pending event. Each request produces exactly one result on m_axis: the event
// fetched by the read (none when no read was requested), a flag that says the
// tick completed a debounce window, and the current debounced level.
// Samples are counted per window of WINDOW_SAMPLES ticks; at the last tick of
// a window the pressed count is compared against vote_threshold and the
// debounced level drives the idle/down/up/finished classifier.
// Each accepted result is registered in the result register, or in the skid
// register while the receiver stalls. Throughput is one request per cycle
// when not stalled, set by the single update stage before out_reg.
// A two-entry output (result register plus skid register) lets the block keep
// accepting while the receiver stalls; s_axis_tready drops only when both are
// full and recovers as soon as the receiver takes a result.
// Reset (rst, synchronous, active high) empties the output, restores the
// register defaults and returns the classifier to idle with no pending event.
// Config writes (cfg_wen, cfg_index, cfg_data) take effect at the next edge.
// The user must issue them only while the block is idle; this is not enforced.
module button_click_long_press_detector_top
  import bclp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Sample channel.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // [0] button_pressed, [1] read_event
  // Result channel.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [1:0] event_code, [2] judged,
                                            // [3] debounced_level
  // Configuration write port.
  input  logic              cfg_wen,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DOWN   = 2'd1,
    PH_UP     = 2'd2,
    PH_FINISH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       judged;
    logic       debounced_level;
  } result_t;

  // Configuration registers.
  logic [THR_W-1:0] vote_threshold;
  logic [CNT_W-1:0] long_press_count;
  logic [CNT_W-1:0] release_count;
  logic [CNT_W-1:0] event_hold_limit;

  // Detector state. Because a judgement only happens once every window slot
  // has been refilled, a running count of pressed samples stands in for the
  // window itself.
  logic [IDX_W-1:0]  sample_index;
  logic [VOTE_W-1:0] votes;
  phase_t            key_phase;
  logic [CNT_W-1:0]  press_counter;
  logic [CNT_W-1:0]  release_counter;
  logic [CNT_W-1:0]  hold_counter;
  event_t            pending_event;
  logic              last_level;

  // Output register and skid register.
  result_t out_reg;
  logic    out_valid;
  result_t skid_reg;
  logic    skid_valid;

  logic accept;
  logic button_pressed;
  logic read_event;

  logic [IDX_W-1:0]  sample_index_next;
  logic [VOTE_W-1:0] votes_next;
  logic [VOTE_W-1:0] votes_sum;
  logic              window_done;
  logic              level;
  phase_t            key_phase_next;
  logic [CNT_W-1:0]  press_counter_next;
  logic [CNT_W-1:0]  release_counter_next;
  logic [CNT_W-1:0]  hold_counter_next;
  event_t            pending_event_next;
  logic              last_level_next;
  logic              classify;
  result_t           result_next;

  assign button_pressed = s_axis_tdata[0];
  assign read_event     = s_axis_tdata[1];
  assign s_axis_tready  = ~skid_valid;
  assign accept         = s_axis_tvalid & s_axis_tready;

  // Window bookkeeping and vote.
  always_comb begin
    votes_sum   = votes + VOTE_W'(button_pressed);
    window_done = (sample_index == IDX_W'(WINDOW_SAMPLES - 1));
    level       = (CMP_W'(votes_sum) >= CMP_W'(vote_threshold));
    if (window_done) begin
      sample_index_next = '0;
      votes_next        = '0;
      last_level_next   = level;
    end else begin
      sample_index_next = sample_index + IDX_W'(1);
      votes_next        = votes_sum;
      last_level_next   = last_level;
    end
  end

  // Classifier update for one judgement, then the event read.
  always_comb begin
    key_phase_next       = key_phase;
    press_counter_next   = press_counter;
    release_counter_next = release_counter;
    hold_counter_next    = hold_counter;
    pending_event_next   = pending_event;
    classify             = window_done;
    result_next          = '0;

    // An unread event blocks classification until the hold time runs out.
    if (window_done && (pending_event != EV_NONE)) begin
      if (hold_counter <= event_hold_limit) begin
        if (hold_counter != CNT_MAX) begin
          hold_counter_next = hold_counter + CNT_W'(1);
        end
        classify = 1'b0;
      end else begin
        pending_event_next = EV_NONE;
      end
    end

    // In the finished phase a release drops to idle and is judged there.
    if (classify && (key_phase == PH_FINISH)) begin
      if (!level) begin
        key_phase_next = PH_IDLE;
      end else begin
        classify = 1'b0;
      end
    end

    if (classify) begin
      case (key_phase_next)
        PH_IDLE: begin
          if (level) begin
            key_phase_next       = PH_DOWN;
            press_counter_next   = '0;
            release_counter_next = '0;
          end
        end
        PH_DOWN: begin
          if (!level) begin
            key_phase_next       = PH_UP;
            release_counter_next = '0;
          end else begin
            if (press_counter != CNT_MAX) begin
              press_counter_next = press_counter + CNT_W'(1);
            end
            if (press_counter_next >= long_press_count) begin
              key_phase_next     = PH_FINISH;
              pending_event_next = EV_LONG;
              hold_counter_next  = '0;
            end
          end
        end
        default: begin
          // The up phase counts every judgement whatever the level.
          if (release_counter != CNT_MAX) begin
            release_counter_next = release_counter + CNT_W'(1);
          end
          if (release_counter_next >= release_count) begin
            key_phase_next     = PH_FINISH;
            pending_event_next = EV_CLICK;
            hold_counter_next  = '0;
          end
        end
      endcase
    end

    if (read_event) begin
      result_next.event_code = pending_event_next;
      pending_event_next     = EV_NONE;
    end
    result_next.judged          = window_done;
    result_next.debounced_level = last_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_threshold   <= VOTE_THRESHOLD_RST;
      long_press_count <= LONG_PRESS_COUNT_RST;
      release_count    <= RELEASE_COUNT_RST;
      event_hold_limit <= EVENT_HOLD_LIMIT_RST;
      sample_index     <= '0;
      votes            <= '0;
      key_phase        <= PH_IDLE;
      press_counter    <= '0;
      release_counter  <= '0;
      hold_counter     <= '0;
      pending_event    <= EV_NONE;
      last_level       <= 1'b0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_VOTE_THRESHOLD:   vote_threshold   <= cfg_data[THR_W-1:0];
          REG_LONG_PRESS_COUNT: long_press_count <= cfg_data[CNT_W-1:0];
          REG_RELEASE_COUNT:    release_count    <= cfg_data[CNT_W-1:0];
          REG_EVENT_HOLD_LIMIT: event_hold_limit <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        sample_index    <= sample_index_next;
        votes           <= votes_next;
        key_phase       <= key_phase_next;
        press_counter   <= press_counter_next;
        release_counter <= release_counter_next;
        hold_counter    <= hold_counter_next;
        pending_event   <= pending_event_next;
        last_level      <= last_level_next;
      end

      // Output register drains into the receiver; the skid register catches
      // a request accepted while the output register is stalled.
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_reg   <= result_next;
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_reg   <= result_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DW - 4){1'b0}}, out_reg.debounced_level, out_reg.judged,
                          out_reg.event_code};

endmodule

@@ tb/sv/button_click_long_press_detector_top_test.sv @@
// Self-checking testbench for button_click_long_press_detector_top: it drives sample
// requests and config writes, and checks every result against a typed row or the predictor.
// Depends on bclp_pkg and the RTL of button_click_long_press_detector_top.
module button_click_long_press_detector_top_test;
  import bclp_pkg::*;

  // Hard stop for a hung run.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the one long receiver hold-off that fills the output stage.
  localparam int HOLD_OFF_CYCLES = 80;

  // Classifier phases as the predictor tracks them.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DOWN   = 2'd1,
    PH_UP     = 2'd2,
    PH_FINISH = 2'd3
  } key_phase_t;

  // One result on m_axis, unpacked into its fields.
  typedef struct packed {
    event_t code;
    logic   judged;
    logic   level;
  } tick_result_t;

  // One row of the opening table. When typed is set, res is the result to expect;
  // otherwise the predictor decides.
  typedef struct packed {
    logic         btn;
    logic         rd;
    logic         typed;
    tick_result_t res;
  } opening_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic              cfg_wen = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  button_click_long_press_detector_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the registers, starting from their reset values.
  logic [THR_W-1:0] vote_thr   = VOTE_THRESHOLD_RST;
  logic [CNT_W-1:0] long_limit = LONG_PRESS_COUNT_RST;
  logic [CNT_W-1:0] rel_limit  = RELEASE_COUNT_RST;
  logic [CNT_W-1:0] hold_limit = EVENT_HOLD_LIMIT_RST;

  // Predictor copy of the block state.
  logic             window_bits [WINDOW_SAMPLES];
  int               win_pos    = 0;
  key_phase_t       phase      = PH_IDLE;
  logic [CNT_W-1:0] press_cnt  = '0;
  logic [CNT_W-1:0] rel_cnt    = '0;
  logic [CNT_W-1:0] hold_cnt   = '0;
  event_t           held_event = EV_NONE;
  logic             deb_level  = 1'b0;

  // Results still owed by the block, oldest first.
  tick_result_t tick_results [$];
  int           mismatch_count = 0;
  int           results_seen   = 0;
  int           cycle_count    = 0;

  // Stimulus shaping shared between the sender, the receiver and the main sequence.
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b0;
  bit stall_request = 1'b0;
  bit run_level     = 1'b0;
  int run_left      = 0;

  // Opening table, two full windows with the reset settings. The first window is
  // typed in: nothing can be judged before the tenth sample, and reads find nothing
  // pending. Its tenth sample closes a window with nine pressed votes against a
  // threshold of eight, so the debounced level turns pressed. The second window has
  // only seven pressed votes and is left to the predictor.
  opening_row_t opening_rows [20] = '{
    '{1'b0, 1'b1, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, '{EV_NONE, 1'b1, 1'b1}},
    '{1'b0, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b0, 1'b1, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{EV_NONE, 1'b0, 1'b0}},
    '{1'b1, 1'b1, 1'b0, '{EV_NONE, 1'b0, 1'b0}}
  };

  // Advances the predicted state by one sample tick and returns the result the
  // block owes for it. The window vote and the classifier come first, the read
  // after, so a read in the tick that raises an event already fetches it.
  function automatic tick_result_t judge_tick(input logic btn, input logic rd);
    tick_result_t r;
    int           votes;
    bit           blocked;
    r       = '{EV_NONE, 1'b0, 1'b0};
    votes   = 0;
    blocked = 1'b0;
    if (win_pos >= WINDOW_SAMPLES) win_pos = 0;
    window_bits[win_pos] = btn;
    win_pos++;
    if (win_pos >= WINDOW_SAMPLES) begin
      for (int i = 0; i < WINDOW_SAMPLES; i++) votes += window_bits[i];
      deb_level = (votes >= int'(vote_thr));
      // An unread event freezes the classifier until it has waited past the hold
      // limit; then it is dropped and this same judgement is classified.
      if (held_event != EV_NONE) begin
        if (hold_cnt <= hold_limit) begin
          if (hold_cnt != CNT_MAX) hold_cnt++;
          blocked = 1'b1;
        end else begin
          held_event = EV_NONE;
        end
      end
      // After an event the button must be released before a new press counts;
      // the release itself is then handled as an idle judgement.
      if (!blocked && phase == PH_FINISH) begin
        if (!deb_level) phase = PH_IDLE;
        else blocked = 1'b1;
      end
      if (!blocked) begin
        case (phase)
          PH_IDLE: begin
            if (deb_level) begin
              phase     = PH_DOWN;
              press_cnt = '0;
              rel_cnt   = '0;
            end
          end
          PH_DOWN: begin
            if (!deb_level) begin
              phase   = PH_UP;
              rel_cnt = '0;
            end else begin
              if (press_cnt != CNT_MAX) press_cnt++;
              if (press_cnt >= long_limit) begin
                phase      = PH_FINISH;
                held_event = EV_LONG;
                hold_cnt   = '0;
              end
            end
          end
          default: begin
            // The up phase counts judgements whatever the level.
            if (rel_cnt != CNT_MAX) rel_cnt++;
            if (rel_cnt >= rel_limit) begin
              phase      = PH_FINISH;
              held_event = EV_CLICK;
              hold_cnt   = '0;
            end
          end
        endcase
      end
      win_pos  = 0;
      r.judged = 1'b1;
    end
    if (rd) begin
      r.code     = held_event;
      held_event = EV_NONE;
    end
    r.level = deb_level;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input tick_result_t want,
                                 input tick_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"result %0d %s: expected code %0d judged %0b level %0b,",
                " got code %0d judged %0b level %0b"},
               results_seen, what, want.code, want.judged, want.level,
               got.code, got.judged, got.level);
  endtask

  // Writes all four registers on consecutive edges. The write enable stays high
  // across them so it is never lowered and raised within one time step.
  task automatic load_settings(input logic [CFG_DW-1:0] thr_word,
                               input logic [CFG_DW-1:0] long_word,
                               input logic [CFG_DW-1:0] rel_word,
                               input logic [CFG_DW-1:0] hold_word);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_VOTE_THRESHOLD;
    cfg_data  <= thr_word;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS_COUNT;
    cfg_data  <= long_word;
    @(posedge clk);
    cfg_index <= REG_RELEASE_COUNT;
    cfg_data  <= rel_word;
    @(posedge clk);
    cfg_index <= REG_EVENT_HOLD_LIMIT;
    cfg_data  <= hold_word;
    @(posedge clk);
    cfg_wen <= 1'b0;
    // Only the low bits of the threshold word are kept.
    vote_thr   = thr_word[THR_W-1:0];
    long_limit = long_word;
    rel_limit  = rel_word;
    hold_limit = hold_word;
  endtask

  // Offers one sample request after a random gap and waits for it to be taken.
  // The expected result is queued at the edge that accepts the request.
  task automatic offer_sample(input logic btn, input logic rd, input logic typed,
                              input tick_result_t typed_res);
    int           gap;
    tick_result_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DW'({rd, btn});
    do @(posedge clk); while (!s_axis_tready);
    predicted = judge_tick(btn, rd);
    tick_results.push_back(typed ? typed_res : predicted);
  endtask

  // Sends one full window. Windows follow runs of a target level so that presses
  // last long enough for clicks and long presses; some windows are pure noise,
  // and the vote count is exact so it lands on either side of the threshold.
  task automatic send_window(input int read_pct);
    int   want;
    int   left;
    int   top;
    logic btn;
    if (run_left == 0) begin
      run_level = !run_level;
      run_left  = $urandom_range(1, 8);
    end
    run_left--;
    top = (vote_thr > WINDOW_SAMPLES) ? WINDOW_SAMPLES : int'(vote_thr);
    if ($urandom_range(0, 99) < 15) want = $urandom_range(0, WINDOW_SAMPLES);
    else if (run_level) want = $urandom_range(top, WINDOW_SAMPLES);
    else want = $urandom_range(0, (top == 0) ? 0 : top - 1);
    left = want;
    for (int k = WINDOW_SAMPLES; k > 0; k--) begin
      btn = ($urandom_range(1, k) <= left);
      if (btn) left--;
      offer_sample(btn, ($urandom_range(0, 99) < read_pct), 1'b0, '0);
    end
  endtask

  // Stops offering and waits until every owed result has come back, then lets
  // the pipeline go quiet before the next register write.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One setting of the registers followed by random windows. With squeeze set the
  // sender never pauses and the receiver holds off for a long stretch, so the
  // output stage fills and the block must stall its input.
  task automatic run_phase(input logic [CFG_DW-1:0] thr_word,
                           input logic [CFG_DW-1:0] long_word,
                           input logic [CFG_DW-1:0] rel_word,
                           input logic [CFG_DW-1:0] hold_word,
                           input int windows, input bit squeeze);
    int read_pct;
    load_settings(thr_word, long_word, rel_word, hold_word);
    // A read rate of zero lets events sit unread until the hold limit drops them.
    read_pct = $urandom_range(0, 30);
    tx_calm  = squeeze || ($urandom_range(0, 3) == 0);
    rx_calm  = ($urandom_range(0, 3) == 0);
    if (squeeze) stall_request = 1'b1;
    repeat (windows) send_window(read_pct);
    settle();
  endtask

  // Receiver: takes results with a random gap before each, and once on request
  // holds off for a long stretch.
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = rx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Result checker and run timeout.
  tick_result_t seen;
  tick_result_t owed;
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = '{event_t'(m_axis_tdata[1:0]), m_axis_tdata[2], m_axis_tdata[3]};
      if (tick_results.size() == 0) begin
        report_mismatch("arrived with no request outstanding", '0, seen);
      end else begin
        owed = tick_results.pop_front();
        if (seen.code !== owed.code || seen.judged !== owed.judged ||
            seen.level !== owed.level)
          report_mismatch("differs", owed, seen);
      end
      results_seen++;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("button_click_long_press_detector_top: mismatch");
      $finish;
    end
  end

  // Main sequence: reset, opening table with the reset settings, then a series of
  // register settings (the extremes first, then random small counts) each followed
  // by random windows.
  initial begin
    for (int i = 0; i < WINDOW_SAMPLES; i++) window_bits[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[i])
      offer_sample(opening_rows[i].btn, opening_rows[i].rd, opening_rows[i].typed,
                   opening_rows[i].res);
    settle();

    // Junk in the upper threshold bits must be dropped; short counts give both events.
    run_phase(16'hFFF5, 16'd3, 16'd2, 16'd3, 6, 1'b0);
    // Threshold zero: every window judges pressed. Zero counts fire at once, and a
    // zero hold limit keeps an unread event for one judgement and drops it at the
    // judgement after that.
    run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4, 1'b0);
    // Threshold above the window: every window judges released. Counts at maximum.
    run_phase(16'h000F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 1'b0);
    // Unanimous vote, single-judgement events, events held until read, plus the
    // long receiver hold-off.
    run_phase(16'h000A, 16'h0001, 16'h0001, 16'hFFFF, 6, 1'b1);
    run_phase(16'h0001, 16'h0002, 16'h0004, 16'hFFFE, 4, 1'b0);
    for (int p = 0; p < 4; p++)
      run_phase(CFG_DW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(1, 10)),
                CFG_DW'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6)),
                CFG_DW'($urandom_range(0, 4)), CFG_DW'($urandom_range(0, 8)), 5, 1'b0);

    if (mismatch_count == 0 && tick_results.size() == 0) begin
      $display("button_click_long_press_detector_top: match");
    end else begin
      $display("button_click_long_press_detector_top: mismatch");
    end
    $finish;
  end

endmodule

@@ button_click_long_press_detector_top.f @@
src/bclp_pkg.sv
src/button_click_long_press_detector_top.sv
tb/sv/button_click_long_press_detector_top_test.sv
